// ----- rtl/core/temp_time_seven_segment_formatter_defines.svh -----
// Assertion macros shared by the checker of the seven-segment formatter.
// Depends on nothing; the including module supplies clk and rst.
`ifndef TEMP_TIME_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH
`define TEMP_TIME_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define TTSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TTSF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ttsf_pkg.sv -----
// Package of the seven-segment formatter: widths, codes, glyph table,
// reciprocal constants and the types passed between its modules.
// Depends on nothing.
package ttsf_pkg;

  localparam int TEMP_W  = 15;
  localparam int MAG_W   = 14;
  localparam int TIME_W  = 13;
  localparam int POS_W   = 4;
  localparam int SEG_W   = 8;
  localparam int GLYPH_W = 7;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW  = TEMP_W'(-999);
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH = TEMP_W'(9999);
  localparam logic [TIME_W-1:0]        TIME_MAX  = TIME_W'(5999);
  localparam logic [MAG_W-1:0]         SHOW_HUND = MAG_W'(99);
  localparam logic [MAG_W-1:0]         SHOW_TENS = MAG_W'(9);

  // Digit positions.
  localparam logic [POS_W-1:0] POS_COOL = POS_W'(3);
  localparam logic [POS_W-1:0] POS_TIME = POS_W'(6);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(9);

  // Digit selectors.
  localparam logic [1:0] TSEL_TENS      = 2'd0;
  localparam logic [1:0] TSEL_HUND      = 2'd1;
  localparam logic [1:0] TSEL_UNITS     = 2'd2;
  localparam logic [1:0] MSEL_MIN_UNITS = 2'd0;
  localparam logic [1:0] MSEL_MIN_TENS  = 2'd1;
  localparam logic [1:0] MSEL_SEC_UNITS = 2'd2;
  localparam logic [1:0] MSEL_SEC_TENS  = 2'd3;

  // Editing modes that gate the decimal point.
  localparam logic [2:0] MODE_0 = 3'd0;
  localparam logic [2:0] MODE_3 = 3'd3;

  // Fixed patterns.
  localparam logic [GLYPH_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [GLYPH_W-1:0] BANNER_0  = 7'h77;
  localparam logic [GLYPH_W-1:0] BANNER_1  = 7'h5E;
  localparam logic [GLYPH_W-1:0] BANNER_2  = 7'h0E;
  localparam logic [GLYPH_W-1:0] BANNER_3  = 7'h78;

  // Quotient by constant: q = (v * RECIP) >> Q_SHIFT, rounded-up reciprocals.
  localparam int Q_SHIFT = 22;
  localparam int RECIP_W = 19;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_10  = RECIP_W'((2**Q_SHIFT + 9) / 10);
  localparam logic [RECIP_W-1:0] RECIP_60  = RECIP_W'((2**Q_SHIFT + 59) / 60);
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((2**Q_SHIFT + 99) / 100);
  localparam logic [RECIP_W-1:0] RECIP_600 = RECIP_W'((2**Q_SHIFT + 599) / 600);

  // Remainder stage: the digit is q mod 10, or q mod 6 for the tens of seconds.
  localparam int M_SHIFT  = 19;
  localparam int MRECIP_W = 17;
  localparam int MPROD_W  = MAG_W + MRECIP_W;
  localparam logic [MRECIP_W-1:0] MRECIP_10 = MRECIP_W'((2**M_SHIFT + 9) / 10);
  localparam logic [MRECIP_W-1:0] MRECIP_6  = MRECIP_W'((2**M_SHIFT + 5) / 6);

  typedef enum logic [2:0] {
    DIV_1,
    DIV_10,
    DIV_60,
    DIV_100,
    DIV_600
  } div_sel_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             blank;
    logic             dot_off;
  } temp_t;

  typedef struct packed {
    temp_t             heat;
    temp_t             cool;
    logic [TIME_W-1:0] secs;
    logic              banner;
    logic              time_blank;
    logic [1:0]        temp_sel;
    logic [1:0]        time_sel;
  } item_t;

  typedef struct packed {
    logic [MAG_W-1:0]   value;
    div_sel_t           div_sel;
    logic               mod6;
    logic               show;
    logic [GLYPH_W-1:0] fixed;
    logic               point;
  } digit_ctl_t;

  function automatic logic [GLYPH_W-1:0] glyph(logic [3:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/ttsf_pos_decode.sv -----
// Per-position decode of the formatter: which value and divisor feed the
// digit, and whether it is shown, blanked, fixed or carries the point.
// Depends on ttsf_pkg.
module ttsf_pos_decode (
  input  ttsf_pkg::item_t              itm,
  input  logic [ttsf_pkg::POS_W-1:0]   pos,
  output ttsf_pkg::digit_ctl_t         ctl
);
  import ttsf_pkg::*;

  temp_t      tp;
  logic [1:0] k;

  always_comb begin
    ctl         = '0;
    ctl.div_sel = DIV_1;
    tp          = (pos < POS_COOL) ? itm.heat : itm.cool;
    k           = '0;
    if (pos < POS_TIME) begin
      k         = (pos < POS_COOL) ? pos[1:0] : 2'(pos - POS_COOL);
      ctl.value = tp.mag;
      case (k)
        2'd0: begin
          if (tp.neg) begin
            ctl.fixed = SEG_MINUS;
          end else begin
            ctl.div_sel = DIV_100;
            ctl.show    = !(itm.temp_sel == TSEL_HUND && tp.blank) && (tp.mag > SHOW_HUND);
          end
        end
        2'd1: begin
          ctl.div_sel = DIV_10;
          ctl.show    = (tp.mag > SHOW_TENS) &&
                        (tp.neg || !(itm.temp_sel == TSEL_TENS && tp.blank));
          ctl.point   = !tp.dot_off;
        end
        default: begin
          ctl.show = tp.neg || !(itm.temp_sel == TSEL_UNITS && tp.blank);
        end
      endcase
    end else begin
      k         = 2'(pos - POS_TIME);
      ctl.value = MAG_W'(itm.secs);
      if (itm.banner) begin
        case (k)
          2'd0:    ctl.fixed = BANNER_0;
          2'd1:    ctl.fixed = BANNER_1;
          2'd2:    ctl.fixed = BANNER_2;
          default: ctl.fixed = BANNER_3;
        endcase
      end else begin
        // Seconds tens is (t / 10) mod 6; the other digits are mod 10.
        case (k)
          2'd0: begin
            ctl.div_sel = DIV_600;
            ctl.show    = !(itm.time_sel == MSEL_MIN_TENS && itm.time_blank);
          end
          2'd1: begin
            ctl.div_sel = DIV_60;
            ctl.show    = !(itm.time_sel == MSEL_MIN_UNITS && itm.time_blank);
            ctl.point   = 1'b1;
          end
          2'd2: begin
            ctl.div_sel = DIV_10;
            ctl.mod6    = 1'b1;
            ctl.show    = !(itm.time_sel == MSEL_SEC_TENS && itm.time_blank);
          end
          default: begin
            ctl.show = !(itm.time_sel == MSEL_SEC_UNITS && itm.time_blank);
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/temp_time_seven_segment_formatter.sv -----
// Seven-segment formatter for two temperatures and a clock time.
// Depends on ttsf_pkg and ttsf_pos_decode.
//
// One transfer on the input channel carries a display snapshot. It yields
// ten transfers on the output channel, digit positions 0 to 9 in order,
// with last_digit set on position 9. Positions 0-2 and 3-5 show the two
// temperatures, 6-9 the time as mm:ss or the calibration banner.
// The snapshot is clamped into an item register. A position counter walks
// it through two stages: a reciprocal multiply that forms the quotient,
// then a remainder multiply and glyph lookup into the output register.
// The first write follows the input transfer through the item register and
// stage one; then one write leaves per cycle while out_ready is high, and the
// next snapshot is taken in the cycle in which position 9 leaves the item
// register. When the receiver stalls, the output holds and the stages behind
// it fill and then stop; nothing is lost. Reset empties all stages and drops
// out_valid; a snapshot taken in flight is discarded.
module temp_time_seven_segment_formatter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ttsf_pkg::TEMP_W-1:0]  heat_value,
  input  logic signed [ttsf_pkg::TEMP_W-1:0]  cool_value,
  input  logic [ttsf_pkg::TIME_W-1:0]         time_seconds,
  input  logic                                calib_banner,
  input  logic                                heat_blank,
  input  logic                                cool_blank,
  input  logic                                time_blank,
  input  logic                                heat_dot_blink,
  input  logic                                cool_dot_blink,
  input  logic [1:0]                          temp_digit_select,
  input  logic [1:0]                          time_digit_select,
  input  logic [2:0]                          set_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttsf_pkg::POS_W-1:0]          digit_position,
  output logic [ttsf_pkg::SEG_W-1:0]          segment_bits,
  output logic                                last_digit
);
  import ttsf_pkg::*;

  item_t              cap;
  item_t              itm;
  logic               itm_valid;
  logic [POS_W-1:0]   pos;
  digit_ctl_t         ctl;

  logic               s1_valid;
  logic [POS_W-1:0]   s1_pos;
  logic [MAG_W-1:0]   s1_q;
  logic               s1_mod6;
  logic               s1_show;
  logic [GLYPH_W-1:0] s1_fixed;
  logic               s1_point;

  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]    q_next;
  logic [MRECIP_W-1:0] mrecip;
  logic [MPROD_W-1:0]  mprod;
  logic [MAG_W-1:0]    quo;
  logic [MAG_W-1:0]    rem;
  logic [SEG_W-1:0]    seg_next;

  logic in_xfer;
  logic s1_load;
  logic out_load;
  logic item_done;

  function automatic temp_t take_temp(logic signed [TEMP_W-1:0] raw, logic blank,
                                      logic dot_off);
    temp_t                    t;
    logic signed [TEMP_W-1:0] c;
    c = raw;
    if (raw < TEMP_LOW) begin
      c = TEMP_LOW;
    end else if (raw > TEMP_HIGH) begin
      c = TEMP_HIGH;
    end
    t.neg     = c[TEMP_W-1];
    t.mag     = c[TEMP_W-1] ? MAG_W'(-c) : MAG_W'(c);
    t.blank   = blank;
    t.dot_off = dot_off;
    return t;
  endfunction

  // Clamping happens on the way into the item register.
  always_comb begin
    cap.heat       = take_temp(heat_value, heat_blank,
                               heat_dot_blink && (set_mode == MODE_0 || set_mode >= MODE_3));
    cap.cool       = take_temp(cool_value, cool_blank,
                               cool_dot_blink && (set_mode == MODE_0 || set_mode == MODE_3));
    cap.secs       = (time_seconds > TIME_MAX) ? TIME_MAX : time_seconds;
    cap.banner     = calib_banner;
    cap.time_blank = time_blank;
    cap.temp_sel   = (temp_digit_select > TSEL_UNITS) ? TSEL_UNITS : temp_digit_select;
    cap.time_sel   = time_digit_select;
  end

  ttsf_pos_decode u_pos_decode (
    .itm (itm),
    .pos (pos),
    .ctl (ctl)
  );

  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign s1_load   = itm_valid && (!s1_valid || out_load);
  assign item_done = s1_load && (pos == LAST_POS);
  assign in_ready  = !itm_valid || item_done;
  assign in_xfer   = in_valid && in_ready;

  // Stage one: quotient of the selected value by 1, 10, 60, 100 or 600.
  always_comb begin
    case (ctl.div_sel)
      DIV_10:  recip = RECIP_10;
      DIV_60:  recip = RECIP_60;
      DIV_100: recip = RECIP_100;
      DIV_600: recip = RECIP_600;
      default: recip = '0;
    endcase
    prod   = PROD_W'(ctl.value) * PROD_W'(recip);
    q_next = (ctl.div_sel == DIV_1) ? ctl.value : MAG_W'(prod >> Q_SHIFT);
  end

  // Stage two: remainder by 10 or 6, then the glyph.
  always_comb begin
    mrecip = s1_mod6 ? MRECIP_6 : MRECIP_10;
    mprod  = MPROD_W'(s1_q) * MPROD_W'(mrecip);
    quo    = MAG_W'(mprod >> M_SHIFT);
    if (s1_mod6) begin
      rem = s1_q - ((quo << 2) + (quo << 1));
    end else begin
      rem = s1_q - ((quo << 3) + (quo << 1));
    end
    seg_next = {s1_point, s1_show ? glyph(rem[3:0]) : s1_fixed};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
      pos       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        itm_valid <= 1'b1;
        pos       <= '0;
      end else if (item_done) begin
        itm_valid <= 1'b0;
      end else if (s1_load) begin
        pos <= pos + 1'b1;
      end
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      itm <= cap;
    end
    if (s1_load) begin
      s1_pos   <= pos;
      s1_q     <= q_next;
      s1_mod6  <= ctl.mod6;
      s1_show  <= ctl.show;
      s1_fixed <= ctl.fixed;
      s1_point <= ctl.point;
    end
    if (out_load) begin
      digit_position <= s1_pos;
      segment_bits   <= seg_next;
      last_digit     <= (s1_pos == LAST_POS);
    end
  end

endmodule

// ----- rtl/core/ttsf_checker.sv -----
// Port-level checker of the seven-segment formatter and its bind.
// Depends on ttsf_pkg and the assertion macro header.
`include "temp_time_seven_segment_formatter_defines.svh"

module ttsf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ttsf_pkg::POS_W-1:0]  digit_position,
  input logic [ttsf_pkg::SEG_W-1:0]  segment_bits,
  input logic                        last_digit
);
  import ttsf_pkg::*;

  `TTSF_ASSERT_RST(a_reset_empty, (rst |=> !out_valid), "output valid after reset")

  `TTSF_ASSERT(a_last_flag, (out_valid |-> (last_digit == (digit_position == LAST_POS))), "last flag off position nine")

  // Back-to-back writes within one refresh step through the positions.
  `TTSF_ASSERT(a_pos_step, (($past(!rst) && $past(out_valid && out_ready && !last_digit) && out_valid) |-> (digit_position == POS_W'($past(digit_position) + 1'b1))), "digit position skipped")

  `TTSF_ASSERT(a_pos_wrap, (($past(!rst) && $past(out_valid && out_ready && last_digit) && out_valid) |-> (digit_position == '0)), "refresh did not restart at position zero")

  `TTSF_ASSERT(a_stall_hold, ((out_valid && !out_ready) |=> (out_valid && $stable(digit_position) && $stable(segment_bits))), "stalled write changed")

endmodule

bind temp_time_seven_segment_formatter ttsf_checker u_checker (.*);
